### rtl/gsff_pkg.sv
// ----------------------------------------------------------------------------
// gsff_pkg
// shared types, constants and tables for the gaussian sum form factor block
// ----------------------------------------------------------------------------
package gsff_pkg;

   // run accumulation limits
   localparam int MAX_RUN   = 65536;
   localparam int RUN_CNT_W = $clog2(MAX_RUN + 1);
   localparam int RUN_SUM_W = 32 + $clog2(MAX_RUN);

   // mean divider sizes
   localparam int DIV_W     = RUN_SUM_W + 1;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   // 1/(4 pi) in q0.32
   localparam logic [31:0] INV_4PI  = 32'd341782638;
   localparam logic [31:0] EXP_ONE  = 32'h8000_0000;
   localparam logic [42:0] X_LIMIT  = 43'd786432;

   // csr register indexes
   localparam logic [2:0] CSR_GAUSS_TERM_0 = 3'd0;
   localparam logic [2:0] CSR_GAUSS_TERM_1 = 3'd1;
   localparam logic [2:0] CSR_GAUSS_TERM_2 = 3'd2;
   localparam logic [2:0] CSR_GAUSS_TERM_3 = 3'd3;
   localparam logic [2:0] CSR_OFFSET_TERM  = 3'd4;

   typedef struct packed {
      logic [23:0] q_value;
      logic        last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] form_factor;
      logic signed [31:0] mean_factor;
      logic               mean_valid;
   } rsp_type;

   // floor((2^32-1)/k), estimate of 1/k for the series divide
   function automatic logic [31:0] recip_of(input logic [3:0] k);
      logic [31:0] r;
      case (k)
         4'd1:    r = 32'hFFFF_FFFF;
         4'd2:    r = 32'h7FFF_FFFF;
         4'd3:    r = 32'h5555_5555;
         4'd4:    r = 32'h3FFF_FFFF;
         4'd5:    r = 32'h3333_3333;
         4'd6:    r = 32'h2AAA_AAAA;
         4'd7:    r = 32'h2492_4924;
         4'd8:    r = 32'h1FFF_FFFF;
         4'd9:    r = 32'h1C71_C71C;
         4'd10:   r = 32'h1999_9999;
         4'd11:   r = 32'h1745_D174;
         4'd12:   r = 32'h1555_5555;
         default: r = 32'h0000_0000;
      endcase
      return r;
   endfunction

endpackage

### rtl/gsff_mul.sv
// ----------------------------------------------------------------------------
// gsff_mul
// shared 32x32 unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module gsff_mul import gsff_pkg::*; (
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [63:0] prod
);

   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   assign prod_in = {32'd0, op_a} * {32'd0, op_b};
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

### rtl/gsff_div.sv
// ----------------------------------------------------------------------------
// gsff_div
// restoring divider for the run mean, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gsff_div import gsff_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_W-1:0]     dividend,
   input  logic [RUN_CNT_W-1:0] divisor,
   output logic                 done,
   output logic [DIV_W-1:0]     quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RUN_CNT_W:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [RUN_CNT_W-1:0] dsr_ff, dsr_in;
   logic [RUN_CNT_W:0]   rem_sh;

   assign rem_sh = {rem_ff[RUN_CNT_W-1:0], quo_ff[DIV_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_W);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = rem_sh - {1'b0, dsr_ff};
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/gaussian_sum_form_factor_top.sv
// ----------------------------------------------------------------------------
// gaussian_sum_form_factor_top
// four-term gaussian atomic form factor with run mean, one shared multiplier
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_ready | req_data  (q_value, last)
//  rsp     | out       | rsp_valid/rsp_ready | rsp_data  (form_factor, mean_factor, mean_valid)
//  csr     | in        | csr_we              | csr_addr, csr_wdata
//
//  one beat at a time: q scaling, then per term the width product, the exp
//  series and the squarings (terms with a large exponent skip these), then
//  the amplitude product
//  the shared 32x32 multiplier sets the pace
//  a beat marked last adds the mean divider, which yields DIV_W quotient bits
//  reset is synchronous and clears the sequencer, csr registers and run state
//  rsp holds in its register until taken; req_ready is low until then
// ----------------------------------------------------------------------------
module gaussian_sum_form_factor_top import gsff_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [63:0] csr_wdata
);

   typedef enum logic [18:0] {
      ST_IDLE = 19'h00001,
      ST_S    = 19'h00002,
      ST_SQ   = 19'h00004,
      ST_X0   = 19'h00008,
      ST_X1   = 19'h00010,
      ST_X2   = 19'h00020,
      ST_X3   = 19'h00040,
      ST_X4   = 19'h00080,
      ST_H0   = 19'h00100,
      ST_H1   = 19'h00200,
      ST_H2   = 19'h00400,
      ST_SQI  = 19'h00800,
      ST_SQR  = 19'h01000,
      ST_AG   = 19'h02000,
      ST_AC   = 19'h04000,
      ST_FIN  = 19'h08000,
      ST_MEAN = 19'h10000,
      ST_DIV  = 19'h20000,
      ST_OUT  = 19'h40000
   } st_type;

   // csr registers
   logic [63:0]        terms_ff [4];
   logic signed [31:0] offset_ff;

   // sequencer and datapath registers
   st_type                    state_ff, state_in;
   logic                      last_ff, last_in;
   logic [41:0]               sq_ff, sq_in;
   logic [58:0]               hx_ff, hx_in;
   logic [36:0]               lo_ff, lo_in;
   logic [30:0]               y_ff, y_in;
   logic [31:0]               e_ff, e_in;
   logic [30:0]               t_ff, t_in;
   logic [3:0]                k_ff, k_in;
   logic [1:0]                sqr_cnt_ff, sqr_cnt_in;
   logic [16:0]               g_ff, g_in;
   logic [1:0]                term_ff, term_in;
   logic signed [51:0]        acc_ff, acc_in;
   logic signed [31:0]        f_ff, f_in;
   logic signed [31:0]        mean_ff, mean_in;
   logic                      neg_ff, neg_in;
   logic signed [RUN_SUM_W-1:0] run_sum_ff, run_sum_in;
   logic [RUN_CNT_W-1:0]      run_count_ff, run_count_in;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;

   // divider
   logic              div_start;
   logic [DIV_W-1:0]  div_dividend;
   logic              div_done;
   logic [DIV_W-1:0]  div_quotient;

   // per-term views
   logic [63:0]        term_word;
   logic [15:0]        b_hi, b_lo;
   logic signed [31:0] amp;
   logic [31:0]        amp_mag;

   // scratch
   logic [28:0]        s_val;
   logic [58:0]        lsq;
   logic [42:0]        x_val;
   logic [31:0]        q0;
   logic [35:0]        q0k;
   logic [35:0]        rem;
   logic [31:0]        quo;
   logic [31:0]        e_sq;
   logic signed [51:0] rnd;
   logic signed [35:0] r_val;
   logic [RUN_SUM_W-1:0] mag;
   logic signed [31:0] mean_q;

   assign term_word = terms_ff[term_ff];
   assign b_hi      = term_word[31:16];
   assign b_lo      = term_word[15:0];
   assign amp       = term_word[63:32];
   assign amp_mag   = amp[31] ? 32'(-amp) : 32'(amp);

   gsff_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   gsff_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (run_count_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      sq_in        = sq_ff;
      hx_in        = hx_ff;
      lo_in        = lo_ff;
      y_in         = y_ff;
      e_in         = e_ff;
      t_in         = t_ff;
      k_in         = k_ff;
      sqr_cnt_in   = sqr_cnt_ff;
      g_in         = g_ff;
      term_in      = term_ff;
      acc_in       = acc_ff;
      f_in         = f_ff;
      mean_in      = mean_ff;
      neg_in       = neg_ff;
      run_sum_in   = run_sum_ff;
      run_count_in = run_count_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;

      s_val  = 29'((prod + 64'd8388608) >> 24);
      lsq    = 59'({prod[36:0], 21'd0}) + 59'(lo_ff);
      x_val  = 43'((hx_ff + (lsq >> 16)) >> 16);
      q0     = prod[63:32];
      q0k    = 36'(q0) * 36'(k_ff);
      rem    = 36'(t_ff) - q0k;
      quo    = (rem >= 36'(k_ff)) ? q0 + 32'd1 : q0;
      e_sq   = 32'((prod + 64'h4000_0000) >> 31);
      rnd    = acc_ff + 52'sd32768;
      r_val  = 36'(rnd >>> 16);
      mag    = run_sum_ff[RUN_SUM_W-1] ? RUN_SUM_W'(-run_sum_ff) : RUN_SUM_W'(run_sum_ff);
      div_dividend = DIV_W'(mag) + DIV_W'(run_count_ff >> 1);
      mean_q = neg_ff ? -32'(div_quotient) : 32'(div_quotient);

      case (state_ff)
         ST_IDLE: begin
            // q times 1/(4 pi)
            mul_a = 32'(req_data.q_value);
            mul_b = INV_4PI;
            if (req_valid) begin
               last_in  = req_data.last;
               term_in  = 2'd0;
               acc_in   = {{4{offset_ff[31]}}, offset_ff, 16'd0};
               state_in = ST_S;
            end
         end
         ST_S: begin
            mul_a    = 32'(s_val);
            mul_b    = 32'(s_val);
            state_in = ST_SQ;
         end
         ST_SQ: begin
            sq_in    = 42'((prod + 64'd32768) >> 16);
            state_in = ST_X0;
         end
         // width times s^2, split over 21-bit halves of s^2
         ST_X0: begin
            mul_a    = 32'(b_hi);
            mul_b    = 32'(sq_ff[20:0]);
            state_in = ST_X1;
         end
         ST_X1: begin
            lo_in    = prod[36:0];
            mul_a    = 32'(b_hi);
            mul_b    = 32'(sq_ff[41:21]);
            state_in = ST_X2;
         end
         ST_X2: begin
            hx_in    = 59'({prod[36:0], 21'd0}) + 59'(lo_ff);
            mul_a    = 32'(b_lo);
            mul_b    = 32'(sq_ff[20:0]);
            state_in = ST_X3;
         end
         ST_X3: begin
            lo_in    = prod[36:0];
            mul_a    = 32'(b_lo);
            mul_b    = 32'(sq_ff[41:21]);
            state_in = ST_X4;
         end
         ST_X4: begin
            if (x_val >= X_LIMIT) begin
               // exponent too large, term vanishes
               g_in     = '0;
               state_in = ST_AG;
            end else begin
               y_in     = {x_val[19:0], 11'd0};
               e_in     = EXP_ONE;
               k_in     = 4'd12;
               state_in = ST_H0;
            end
         end
         // horner series for exp(-y)
         ST_H0: begin
            mul_a    = 32'(y_ff);
            mul_b    = e_ff;
            state_in = ST_H1;
         end
         ST_H1: begin
            t_in     = prod[61:31];
            mul_a    = 32'(prod[61:31]);
            mul_b    = recip_of(k_ff);
            state_in = ST_H2;
         end
         ST_H2: begin
            e_in = EXP_ONE - quo;
            if (k_ff == 4'd1) begin
               sqr_cnt_in = '0;
               state_in   = ST_SQI;
            end else begin
               k_in     = k_ff - 4'd1;
               state_in = ST_H0;
            end
         end
         // four squarings undo the divide by 16
         ST_SQI: begin
            mul_a    = e_ff;
            mul_b    = e_ff;
            state_in = ST_SQR;
         end
         ST_SQR: begin
            e_in = e_sq;
            if (sqr_cnt_ff == 2'd3) begin
               g_in     = 17'((33'(e_sq) + 33'd16384) >> 15);
               state_in = ST_AG;
            end else begin
               sqr_cnt_in = sqr_cnt_ff + 2'd1;
               state_in   = ST_SQI;
            end
         end
         ST_AG: begin
            mul_a    = amp_mag;
            mul_b    = 32'(g_ff);
            state_in = ST_AC;
         end
         ST_AC: begin
            if (amp[31]) begin
               acc_in = acc_ff - 52'(prod[48:0]);
            end else begin
               acc_in = acc_ff + 52'(prod[48:0]);
            end
            if (term_ff == 2'd3) begin
               state_in = ST_FIN;
            end else begin
               term_in  = term_ff + 2'd1;
               state_in = ST_X0;
            end
         end
         ST_FIN: begin
            if (r_val > 36'sd2147483647) begin
               f_in = 32'sh7FFF_FFFF;
            end else if (r_val < -36'sd2147483648) begin
               f_in = 32'sh8000_0000;
            end else begin
               f_in = 32'(r_val);
            end
            if (run_count_ff < RUN_CNT_W'(MAX_RUN)) begin
               run_sum_in   = run_sum_ff + RUN_SUM_W'(f_in);
               run_count_in = run_count_ff + 1'b1;
            end
            state_in = ST_MEAN;
         end
         ST_MEAN: begin
            mean_in = '0;
            if (last_ff && (run_count_ff != '0)) begin
               neg_in    = run_sum_ff[RUN_SUM_W-1];
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               if (last_ff) begin
                  run_sum_in   = '0;
                  run_count_in = '0;
               end
               state_in = ST_OUT;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               mean_in      = mean_q;
               run_sum_in   = '0;
               run_count_in = '0;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_sum_ff   <= '0;
         run_count_ff <= '0;
         offset_ff    <= '0;
         for (int i = 0; i < 4; i++) begin
            terms_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         run_sum_ff   <= run_sum_in;
         run_count_ff <= run_count_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_GAUSS_TERM_0: terms_ff[0] <= csr_wdata;
               CSR_GAUSS_TERM_1: terms_ff[1] <= csr_wdata;
               CSR_GAUSS_TERM_2: terms_ff[2] <= csr_wdata;
               CSR_GAUSS_TERM_3: terms_ff[3] <= csr_wdata;
               CSR_OFFSET_TERM:  offset_ff   <= csr_wdata[31:0];
               default: begin
               end
            endcase
         end
      end
      last_ff    <= last_in;
      sq_ff      <= sq_in;
      hx_ff      <= hx_in;
      lo_ff      <= lo_in;
      y_ff       <= y_in;
      e_ff       <= e_in;
      t_ff       <= t_in;
      k_ff       <= k_in;
      sqr_cnt_ff <= sqr_cnt_in;
      g_ff       <= g_in;
      term_ff    <= term_in;
      acc_ff     <= acc_in;
      f_ff       <= f_in;
      mean_ff    <= mean_in;
      neg_ff     <= neg_in;
   end

   assign req_ready            = (state_ff == ST_IDLE);
   assign rsp_valid            = (state_ff == ST_OUT);
   assign rsp_data.form_factor = f_ff;
   assign rsp_data.mean_factor = mean_ff;
   assign rsp_data.mean_valid  = last_ff;

   // never take a new beat while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req_ready and rsp_valid both high");

   // run count never passes the run limit
   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      run_count_ff <= RUN_CNT_W'(MAX_RUN))
      else $error("run count beyond limit");

   // a beat without the mean carries a zero mean
   a_mean_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.mean_valid |-> rsp_data.mean_factor == 32'sd0)
      else $error("mean without last");

   // run state is already cleared when a last beat is delivered
   a_run_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.mean_valid |=> run_count_ff == '0)
      else $error("run not cleared after last");

endmodule
